FILE: design/ilir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared types and constants for the indexed list insert/remove core.
// ----------------------------------------------------------------------------
package ilir_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int DATA_W          = 32;
	localparam int POS_W           = 8;
	localparam int CNT_W           = 9;

	typedef enum logic [2:0] {
		FUNC_READ   = 3'd0,
		FUNC_WRITE  = 3'd1,
		FUNC_INSERT = 3'd2,
		FUNC_REMOVE = 3'd3,
		FUNC_RESIZE = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// what every cell of the row does in the current cycle
	typedef enum logic [2:0] {
		CMD_NONE   = 3'd0,
		CMD_WRITE  = 3'd1,
		CMD_INSERT = 3'd2,
		CMD_REMOVE = 3'd3,
		CMD_GROW   = 3'd4
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t           op;
		logic [CNT_W-1:0]  pos;
		logic [CNT_W-1:0]  len;
		logic [CNT_W-1:0]  newlen;
		logic [DATA_W-1:0] data;
	} cmd_t;

endpackage

FILE: design/ilir_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilir_cell
// One entry of the list: loads, shifts from a neighbor or clears itself
// according to the broadcast command, and drives its word on a read match.
// ----------------------------------------------------------------------------
module ilir_cell #(
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ilir_pkg::cmd_t             cmd,
	input  logic [ilir_pkg::DATA_W-1:0] prev_data,
	input  logic [ilir_pkg::DATA_W-1:0] next_data,
	output logic [ilir_pkg::DATA_W-1:0] data,
	output logic [ilir_pkg::DATA_W-1:0] rd_data
);

	localparam logic [ilir_pkg::CNT_W-1:0] IDX_V = ilir_pkg::CNT_W'(IDX);

	logic [ilir_pkg::DATA_W-1:0] data_q;
	logic [ilir_pkg::CNT_W:0]    idx_plus1;

	assign idx_plus1 = {1'b0, IDX_V} + (ilir_pkg::CNT_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else begin
			unique case (cmd.op)
				ilir_pkg::CMD_WRITE: begin
					if (IDX_V == cmd.pos) data_q <= cmd.data;
				end
				ilir_pkg::CMD_INSERT: begin
					if (IDX_V == cmd.pos) data_q <= cmd.data;
					else if (IDX_V > cmd.pos && IDX_V <= cmd.len) data_q <= prev_data;
				end
				ilir_pkg::CMD_REMOVE: begin
					// the last valid entry keeps its stale word
					if (IDX_V >= cmd.pos && idx_plus1 < {1'b0, cmd.len}) data_q <= next_data;
				end
				ilir_pkg::CMD_GROW: begin
					if (IDX_V >= cmd.len && IDX_V < cmd.newlen) data_q <= '0;
				end
				default: begin
					data_q <= data_q;
				end
			endcase
		end
	end

	assign data    = data_q;
	assign rd_data = (IDX_V == cmd.pos) ? data_q : '0;

endmodule

FILE: design/indexed_list_insert_remove_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_core
// Ordered list of signed 32-bit words with read, write, insert, remove and
// resize at a position, one result per operation.
// ----------------------------------------------------------------------------
// The core takes one operation per clock cycle and returns its result in the
// next cycle through an output register, so throughput stays at one item per
// cycle as long as the result side keeps taking transfers. The list lives in a
// row of MAX_ENTRIES entry cells that all update in the same cycle, so an
// insert or remove shifts the whole tail at once; a read selects the matching
// cell's word. After reset the list is empty and every entry reads as zero.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_core #(
	parameter int MAX_ENTRIES = ilir_pkg::MAX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // position[7:0], write_data[39:8], new_length[48:40], zero
	input  logic [2:0]  s_tuser,  // func[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // read_data[31:0], list_length[40:32], zero
	output logic [1:0]  m_tuser   // status[1:0]
);

	localparam int LW = $clog2(MAX_ENTRIES + 1);
	localparam logic [ilir_pkg::CNT_W-1:0] MAX_V = ilir_pkg::CNT_W'(MAX_ENTRIES);

	logic                          accept;
	ilir_pkg::func_t               func;
	logic [ilir_pkg::CNT_W-1:0]    pos9;
	logic [ilir_pkg::DATA_W-1:0]   wdata;
	logic [ilir_pkg::CNT_W-1:0]    newlen;
	logic [ilir_pkg::CNT_W-1:0]    len9;

	logic [LW-1:0]                 len_q;
	logic [LW-1:0]                 len_d;
	ilir_pkg::status_t             st_d;
	ilir_pkg::cmd_op_t             op_d;
	logic                          rd_ok;
	ilir_pkg::cmd_t                cmd;

	logic [ilir_pkg::DATA_W-1:0]   cell_data [MAX_ENTRIES];
	logic [ilir_pkg::DATA_W-1:0]   cell_rd   [MAX_ENTRIES];
	logic [ilir_pkg::DATA_W-1:0]   rd_any;

	logic                          m_valid_q;
	logic [ilir_pkg::DATA_W-1:0]   rdata_q;
	logic [ilir_pkg::CNT_W-1:0]    olen_q;
	ilir_pkg::status_t             status_q;

	assign func   = ilir_pkg::func_t'(s_tuser);
	assign pos9   = {1'b0, s_tdata[7:0]};
	assign wdata  = s_tdata[39:8];
	assign newlen = s_tdata[48:40];
	assign len9   = ilir_pkg::CNT_W'(len_q);

	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		len_d = len_q;
		st_d  = ilir_pkg::ST_OK;
		op_d  = ilir_pkg::CMD_NONE;
		rd_ok = 1'b0;
		unique case (func)
			ilir_pkg::FUNC_READ: begin
				if (pos9 < len9) rd_ok = 1'b1;
				else st_d = ilir_pkg::ST_RANGE;
			end
			ilir_pkg::FUNC_WRITE: begin
				if (pos9 < len9) op_d = ilir_pkg::CMD_WRITE;
				else st_d = ilir_pkg::ST_RANGE;
			end
			ilir_pkg::FUNC_INSERT: begin
				// position is checked before fullness
				priority if (pos9 > len9) begin
					st_d = ilir_pkg::ST_RANGE;
				end else if (len9 >= MAX_V) begin
					st_d = ilir_pkg::ST_FULL;
				end else begin
					op_d  = ilir_pkg::CMD_INSERT;
					len_d = LW'(len_q + 1'b1);
				end
			end
			ilir_pkg::FUNC_REMOVE: begin
				priority if (len9 == '0) begin
					st_d = ilir_pkg::ST_EMPTY;
				end else if (pos9 >= len9) begin
					st_d = ilir_pkg::ST_RANGE;
				end else begin
					op_d  = ilir_pkg::CMD_REMOVE;
					len_d = LW'(len_q - 1'b1);
				end
			end
			ilir_pkg::FUNC_RESIZE: begin
				if (newlen > MAX_V) begin
					st_d = ilir_pkg::ST_RANGE;
				end else begin
					op_d  = ilir_pkg::CMD_GROW;
					len_d = newlen[LW-1:0];
				end
			end
			default: begin
				st_d = ilir_pkg::ST_OK;
			end
		endcase
	end

	always_comb begin
		cmd.op     = accept ? op_d : ilir_pkg::CMD_NONE;
		cmd.pos    = pos9;
		cmd.len    = len9;
		cmd.newlen = newlen;
		cmd.data   = wdata;
	end

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic [ilir_pkg::DATA_W-1:0] prev_w;
		logic [ilir_pkg::DATA_W-1:0] next_w;

		if (i == 0) begin : g_first
			assign prev_w = '0;
		end else begin : g_prev
			assign prev_w = cell_data[i-1];
		end
		if (i == MAX_ENTRIES - 1) begin : g_last
			assign next_w = '0;
		end else begin : g_next
			assign next_w = cell_data[i+1];
		end

		ilir_cell #(
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.prev_data(prev_w),
			.next_data(next_w),
			.data     (cell_data[i]),
			.rd_data  (cell_rd[i])
		);
	end

	always_comb begin
		rd_any = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			rd_any = rd_any | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				len_q     <= len_d;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_q  <= rd_ok ? rd_any : '0;
			olen_q   <= ilir_pkg::CNT_W'(len_d);
			status_q <= st_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, olen_q, rdata_q};
	assign m_tuser  = status_q;

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len9 <= MAX_V)
		else $error("list length above capacity");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted operation gave no result");

	a_fail_keeps_len: assert property (@(posedge clk) disable iff (!arst_n)
		accept && st_d != ilir_pkg::ST_OK |=> $stable(len_q))
		else $error("failing operation changed the length");

	a_err_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && status_q != ilir_pkg::ST_OK |-> rdata_q == '0)
		else $error("error result carries nonzero read data");
`endif

endmodule

FILE: sim/tb_indexed_list_insert_remove_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_insert_remove_core
// Self-checking bench for the indexed list core: a local list model predicts
// every result, random idle gaps on both stream sides plus one long output
// hold-off, directed corner cases followed by biased random operation mixes.
// ----------------------------------------------------------------------------
module tb_indexed_list_insert_remove_core;

	localparam int LIST_DEPTH = ilir_pkg::MAX_ENTRIES_DEF;
	localparam int TIMEOUT_NS = 1_500_000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
	localparam logic [2:0] FUNC_SPARE_LAST = 3'd7;

	typedef struct {
		logic [31:0]       rdata;
		logic [8:0]        len;
		ilir_pkg::status_t st;
	} list_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;  // position[7:0], write_data[39:8], new_length[48:40], zero
	logic [2:0]  s_tuser;  // func[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;  // read_data[31:0], list_length[40:32], zero
	logic [1:0]  m_tuser;  // status[1:0]

	// local copy of the list
	logic [31:0] model_words [LIST_DEPTH];
	int          model_len;

	list_result_t pending_results [$];
	int           mismatch_count;
	bit           src_burst;
	bit           sink_burst;
	int           hold_req;

	indexed_list_insert_remove_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic list_result_t apply_list_op(input logic [2:0] op, input logic [7:0] pos,
			input logic [31:0] wdata, input logic [8:0] newlen);
		list_result_t r;
		int p;
		int nl;
		int i;
		r.rdata = '0;
		r.st = ilir_pkg::ST_OK;
		p = pos;
		nl = newlen;
		case (op)
			ilir_pkg::FUNC_READ: begin
				if (p < model_len) r.rdata = model_words[p];
				else r.st = ilir_pkg::ST_RANGE;
			end
			ilir_pkg::FUNC_WRITE: begin
				if (p < model_len) model_words[p] = wdata;
				else r.st = ilir_pkg::ST_RANGE;
			end
			ilir_pkg::FUNC_INSERT: begin
				if (p > model_len) begin
					r.st = ilir_pkg::ST_RANGE;
				end else if (model_len >= LIST_DEPTH) begin
					r.st = ilir_pkg::ST_FULL;
				end else begin
					for (i = model_len; i > p; i--) model_words[i] = model_words[i-1];
					model_words[p] = wdata;
					model_len++;
				end
			end
			ilir_pkg::FUNC_REMOVE: begin
				if (model_len == 0) begin
					r.st = ilir_pkg::ST_EMPTY;
				end else if (p >= model_len) begin
					r.st = ilir_pkg::ST_RANGE;
				end else begin
					for (i = p; i + 1 < model_len; i++) model_words[i] = model_words[i+1];
					model_len--;
				end
			end
			ilir_pkg::FUNC_RESIZE: begin
				if (nl > LIST_DEPTH) begin
					r.st = ilir_pkg::ST_RANGE;
				end else begin
					// growth clears the stale words above the old length
					for (i = model_len; i < nl; i++) model_words[i] = '0;
					model_len = nl;
				end
			end
			default: ;
		endcase
		r.len = model_len[8:0];
		return r;
	endfunction

	task automatic note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) $display("%0t ns: %s", $time, msg);
	endtask

	// one input transfer; entered right after a rising edge
	task automatic send_op(input logic [2:0] op, input logic [7:0] pos,
			input logic [31:0] wdata, input logic [8:0] newlen);
		int gap;
		gap = src_burst ? 0 : $urandom_range(0, 14);
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, newlen, wdata, pos};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(apply_list_op(op, pos, wdata, newlen));
	endtask

	task automatic send_random_op(input int grow_w, input int shrink_w);
		logic [2:0]  op;
		logic [7:0]  pos;
		logic [31:0] wdata;
		logic [8:0]  newlen;
		int          pick;
		pick = $urandom_range(0, 25 + 20 + grow_w + shrink_w + 8 + 3 - 1);
		if (pick < 25) op = ilir_pkg::FUNC_READ;
		else if (pick < 45) op = ilir_pkg::FUNC_WRITE;
		else if (pick < 45 + grow_w) op = ilir_pkg::FUNC_INSERT;
		else if (pick < 45 + grow_w + shrink_w) op = ilir_pkg::FUNC_REMOVE;
		else if (pick < 53 + grow_w + shrink_w) op = ilir_pkg::FUNC_RESIZE;
		else op = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));

		// mostly legal positions so the shifts see real content
		if ($urandom_range(0, 9) < 8) begin
			if (op == ilir_pkg::FUNC_INSERT) pos = 8'($urandom_range(0, model_len));
			else if (model_len > 0) pos = 8'($urandom_range(0, model_len - 1));
			else pos = '0;
		end else begin
			pos = 8'($urandom_range(0, 255));
		end

		case ($urandom_range(0, 19))
			0: wdata = 32'h8000_0000;
			1: wdata = 32'h7fff_ffff;
			2: wdata = 32'hffff_ffff;
			3: wdata = '0;
			default: wdata = $urandom();
		endcase

		if ($urandom_range(0, 99) < 85) newlen = 9'($urandom_range(0, LIST_DEPTH));
		else newlen = 9'($urandom_range(LIST_DEPTH + 1, 511));

		send_op(op, pos, wdata, newlen);
	endtask

	// receiver: random stall per result, one long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin : sink_loop
			int stall;
			@(negedge clk);
			if (hold_req != 0) begin
				m_tready <= 1'b0;
				repeat (hold_req) @(negedge clk);
				hold_req = 0;
			end
			stall = sink_burst ? 0 : $urandom_range(0, 14);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin : result_check
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				note_mismatch("result transfer with nothing outstanding");
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[31:0] !== want.rdata)
					note_mismatch($sformatf("read_data exp %h got %h", want.rdata,
						m_tdata[31:0]));
				if (m_tdata[40:32] !== want.len)
					note_mismatch($sformatf("list_length exp %0d got %0d", want.len,
						m_tdata[40:32]));
				if (m_tuser !== want.st)
					note_mismatch($sformatf("status exp %0d got %0d", want.st, m_tuser));
			end
		end
	end

	task automatic test_empty_list;
		send_op(ilir_pkg::FUNC_READ, 8'd0, 32'h1111_1111, 9'd0);
		send_op(ilir_pkg::FUNC_WRITE, 8'd0, 32'h2222_2222, 9'd0);
		// empty wins over a bad position
		send_op(ilir_pkg::FUNC_REMOVE, 8'd5, 32'd0, 9'd0);
		send_op(ilir_pkg::FUNC_INSERT, 8'd1, 32'h3333_3333, 9'd0);
		send_op(ilir_pkg::FUNC_RESIZE, 8'd0, 32'd0, 9'd0);
	endtask

	task automatic test_insert_remove;
		send_op(ilir_pkg::FUNC_INSERT, 8'd0, 32'h8000_0000, 9'd0);
		send_op(ilir_pkg::FUNC_INSERT, 8'd1, 32'h7fff_ffff, 9'd0);
		send_op(ilir_pkg::FUNC_INSERT, 8'd1, 32'h1234_5678, 9'd0);
		send_op(ilir_pkg::FUNC_READ, 8'd1, 32'd0, 9'd0);
		send_op(ilir_pkg::FUNC_WRITE, 8'd2, 32'hffff_ffff, 9'd0);
		send_op(ilir_pkg::FUNC_REMOVE, 8'd0, 32'd0, 9'd0);
		send_op(ilir_pkg::FUNC_READ, 8'd0, 32'd0, 9'd0);
		send_op(ilir_pkg::FUNC_REMOVE, 8'd2, 32'd0, 9'd0);
	endtask

	task automatic test_resize_limits;
		send_op(ilir_pkg::FUNC_RESIZE, 8'd0, 32'd0, 9'(LIST_DEPTH));
		send_op(ilir_pkg::FUNC_READ, 8'(LIST_DEPTH - 1), 32'd0, 9'd0);
		// position above length is flagged before fullness
		send_op(ilir_pkg::FUNC_INSERT, 8'(LIST_DEPTH + 1), 32'h5555_5555, 9'd0);
		send_op(ilir_pkg::FUNC_INSERT, 8'(LIST_DEPTH), 32'h5555_5555, 9'd0);
		send_op(ilir_pkg::FUNC_READ, 8'd255, 32'd0, 9'd0);
		send_op(ilir_pkg::FUNC_RESIZE, 8'd0, 32'd0, 9'(LIST_DEPTH + 1));
		send_op(ilir_pkg::FUNC_RESIZE, 8'd0, 32'd0, 9'd256);
		send_op(ilir_pkg::FUNC_WRITE, 8'd3, 32'ha5a5_a5a5, 9'd0);
		send_op(ilir_pkg::FUNC_RESIZE, 8'd0, 32'd0, 9'd2);
		send_op(ilir_pkg::FUNC_RESIZE, 8'd0, 32'd0, 9'd5);
		send_op(ilir_pkg::FUNC_READ, 8'd3, 32'd0, 9'd0);
	endtask

	task automatic test_unused_codes;
		for (int c = FUNC_SPARE_FIRST; c <= FUNC_SPARE_LAST; c++)
			send_op(3'(c), 8'hff, 32'hdead_beef, 9'h1ff);
	endtask

	task automatic test_backpressure;
		hold_req = HOLD_CYCLES;
		src_burst = 1'b1;
		repeat (40) send_random_op(20, 20);
		src_burst = 1'b0;
	endtask

	task automatic test_random;
		for (int phase = 0; phase < 4; phase++) begin
			for (int n = 0; n < 400; n++) begin
				if (n % 50 == 0) begin
					src_burst = ($urandom_range(0, 3) == 0);
					sink_burst = ($urandom_range(0, 3) == 0);
				end
				case (phase)
					0: send_random_op(20, 20);
					1: send_random_op(45, 8);
					2: send_random_op(8, 45);
					default: send_random_op(30, 15);
				endcase
			end
		end
		src_burst = 1'b0;
		sink_burst = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		mismatch_count = 0;
		src_burst = 1'b0;
		sink_burst = 1'b0;
		hold_req = 0;
		model_len = 0;
		foreach (model_words[i]) model_words[i] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_empty_list();
		test_insert_remove();
		test_resize_limits();
		test_unused_codes();
		test_backpressure();
		test_random();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0) note_mismatch("results still outstanding");
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
design/ilir_pkg.sv
design/ilir_cell.sv
design/indexed_list_insert_remove_core.sv
sim/tb_indexed_list_insert_remove_core.sv
